// ===== rtl/core/hpt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpt_pkg
// Types, constants and codes shared by the hotspot profile table modules.
// ----------------------------------------------------------------------------
package hpt_pkg;

  localparam int unsigned TABLE_ENTRIES = 32;
  localparam int unsigned MAX_RESULTS   = 32;
  localparam int unsigned IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int unsigned CNT_W         = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned REQ_W         = 6;
  localparam int unsigned LIM_W         = (REQ_W > CNT_W) ? REQ_W : CNT_W;
  localparam int unsigned RANK_W        = 5;
  localparam int unsigned PC_W          = 32;
  localparam int unsigned EXEC_W        = 32;
  localparam int unsigned CYC_IN_W      = 32;
  localparam int unsigned CYC_W         = 48;
  localparam int unsigned AVG_W         = 32;
  localparam int unsigned DIV_CNT_W     = $clog2(CYC_W + 1);

  typedef enum logic [1:0] {
    KIND_RECORD = 2'd0,
    KIND_QUERY  = 2'd1,
    KIND_CLEAR  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REC_SCAN,
    ST_QRY_SCAN,
    ST_QRY_DIV,
    ST_QRY_LOAD
  } state_e;

  typedef struct packed {
    logic accept;
    logic clear;
    logic scan_start;
    logic scan_run;
    logic qry_mode;
    logic rec_commit;
    logic qry_init;
    logic pick;
    logic out_load;
    logic rank_next;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       limit_zero;
    logic       scan_done;
    logic       div_done;
    logic       out_free;
    logic       last_rank;
    logic       empty;
  } sts_t;

endpackage

// ===== rtl/core/hpt_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpt_in_if / hpt_out_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface hpt_in_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   kind;
  logic [hpt_pkg::PC_W-1:0]     pc;
  logic [hpt_pkg::CYC_IN_W-1:0] cycles;
  logic [hpt_pkg::REQ_W-1:0]    want_count;

  modport source (output valid, kind, pc, cycles, want_count, input ready);
  modport sink (input valid, kind, pc, cycles, want_count, output ready);
endinterface

interface hpt_out_if;
  logic                       valid;
  logic                       ready;
  logic [hpt_pkg::RANK_W-1:0] rank;
  logic                       entry_valid;
  logic [hpt_pkg::PC_W-1:0]   hot_pc;
  logic [hpt_pkg::EXEC_W-1:0] executions;
  logic [hpt_pkg::CYC_W-1:0]  total_cycles;
  logic [hpt_pkg::AVG_W-1:0]  average_cycles;
  logic                       table_overflow;
  logic                       last;

  modport source (output valid, rank, entry_valid, hot_pc, executions, total_cycles,
                  average_cycles, table_overflow, last, input ready);
  modport sink (input valid, rank, entry_valid, hot_pc, executions, total_cycles,
                average_cycles, table_overflow, last, output ready);
endinterface

// ===== rtl/core/hotspot_profile_table.sv =====
`timescale 1ns / 1ps
// Record: the pc scan reads one slot a cycle over the used slots. Query: after the accept, per
//   result a ranking scan, a bit-serial divide and a load, held while the previous result waits
//   for ready. An empty query goes straight to the load. Clear: done on accept, with no further
//   state.
// One item at a time; the next item is taken while the last result waits.
// Reset empties the table and drops the overflow flag; slot contents are not cleared.
// ----------------------------------------------------------------------------
// hotspot_profile_table
// Program counter profile table with saturating counters and ranked queries.
// ----------------------------------------------------------------------------
module hotspot_profile_table (
  input  logic     clk_i,
  input  logic     rst_ni,
  hpt_in_if.sink   in_i,
  hpt_out_if.source out_o
);

  hpt_pkg::cmd_t cmd;
  hpt_pkg::sts_t sts;

  hpt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  hpt_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_kind_i   (in_i.kind),
    .in_pc_i     (in_i.pc),
    .in_cycles_i (in_i.cycles),
    .in_want_i   (in_i.want_count),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_o       (out_o)
  );

endmodule

// ===== rtl/core/hpt_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpt_ctrl
// Sequencer for record scans, query ranking, division and result loading.
// ----------------------------------------------------------------------------
module hpt_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  hpt_pkg::sts_t sts_i,
  output hpt_pkg::cmd_t cmd_o
);

  hpt_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hpt_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      hpt_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (sts_i.kind == hpt_pkg::KIND_RECORD) begin
            state_d = hpt_pkg::ST_REC_SCAN;
          end else if (sts_i.kind == hpt_pkg::KIND_QUERY) begin
            state_d = sts_i.limit_zero ? hpt_pkg::ST_QRY_LOAD : hpt_pkg::ST_QRY_SCAN;
          end
        end
      end
      hpt_pkg::ST_REC_SCAN: begin
        if (sts_i.scan_done) state_d = hpt_pkg::ST_IDLE;
      end
      hpt_pkg::ST_QRY_SCAN: begin
        if (sts_i.scan_done) state_d = hpt_pkg::ST_QRY_DIV;
      end
      hpt_pkg::ST_QRY_DIV: begin
        if (sts_i.div_done) state_d = hpt_pkg::ST_QRY_LOAD;
      end
      hpt_pkg::ST_QRY_LOAD: begin
        if (sts_i.out_free) begin
          state_d = (sts_i.empty || sts_i.last_rank) ? hpt_pkg::ST_IDLE
                                                     : hpt_pkg::ST_QRY_SCAN;
        end
      end
      default: state_d = hpt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      hpt_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (sts_i.kind == hpt_pkg::KIND_RECORD) begin
            cmd_o.scan_start = 1'b1;
          end else if (sts_i.kind == hpt_pkg::KIND_QUERY) begin
            cmd_o.qry_init   = 1'b1;
            cmd_o.scan_start = !sts_i.limit_zero;
          end else if (sts_i.kind == hpt_pkg::KIND_CLEAR) begin
            cmd_o.clear = 1'b1;
          end
        end
      end
      hpt_pkg::ST_REC_SCAN: begin
        cmd_o.scan_run   = 1'b1;
        cmd_o.rec_commit = sts_i.scan_done;
      end
      hpt_pkg::ST_QRY_SCAN: begin
        cmd_o.scan_run = 1'b1;
        cmd_o.qry_mode = 1'b1;
        cmd_o.pick     = sts_i.scan_done;
      end
      hpt_pkg::ST_QRY_DIV: ;
      hpt_pkg::ST_QRY_LOAD: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          if (!(sts_i.empty || sts_i.last_rank)) begin
            cmd_o.rank_next  = 1'b1;
            cmd_o.scan_start = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_ready_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> state_q == hpt_pkg::ST_IDLE)
    else $error("input taken outside idle");
  a_commit_ends_rec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.rec_commit |=> state_q == hpt_pkg::ST_IDLE)
    else $error("record did not finish after commit");
  a_pick_to_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.pick |=> state_q == hpt_pkg::ST_QRY_DIV)
    else $error("pick not followed by divide");
`endif

endmodule

// ===== rtl/core/hpt_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpt_dp
// Slot memories, scan compare, saturating update, divider and result register.
// ----------------------------------------------------------------------------
module hpt_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [1:0]                   in_kind_i,
  input  logic [hpt_pkg::PC_W-1:0]     in_pc_i,
  input  logic [hpt_pkg::CYC_IN_W-1:0] in_cycles_i,
  input  logic [hpt_pkg::REQ_W-1:0]    in_want_i,
  input  hpt_pkg::cmd_t                cmd_i,
  output hpt_pkg::sts_t                sts_o,
  hpt_out_if.source                    out_o
);

  localparam int unsigned N = hpt_pkg::TABLE_ENTRIES;

  logic [hpt_pkg::PC_W-1:0]   mem_pc   [N];
  logic [hpt_pkg::EXEC_W-1:0] mem_exec [N];
  logic [hpt_pkg::CYC_W-1:0]  mem_cyc  [N];

  logic [hpt_pkg::CNT_W-1:0]    used_q, idx_q;
  logic                         ovf_q;
  logic [N-1:0]                 mask_q;
  logic [hpt_pkg::PC_W-1:0]     pc_q;
  logic [hpt_pkg::CYC_IN_W-1:0] cyc_q;
  logic [hpt_pkg::LIM_W-1:0]    limit_q;
  logic                         empty_q;
  logic [hpt_pkg::RANK_W-1:0]   rank_q;

  logic                       rd_vld_q;
  logic [hpt_pkg::IDX_W-1:0]  rd_idx_q;
  logic [hpt_pkg::PC_W-1:0]   rd_pc_q;
  logic [hpt_pkg::EXEC_W-1:0] rd_exec_q;
  logic [hpt_pkg::CYC_W-1:0]  rd_cyc_q;

  logic                       found_q;
  logic [hpt_pkg::IDX_W-1:0]  best_idx_q;
  logic [hpt_pkg::PC_W-1:0]   best_pc_q;
  logic [hpt_pkg::EXEC_W-1:0] best_exec_q;
  logic [hpt_pkg::CYC_W-1:0]  best_cyc_q;

  logic [hpt_pkg::DIV_CNT_W-1:0] div_cnt_q;
  logic [hpt_pkg::CYC_W-1:0]     quo_q;
  logic [hpt_pkg::EXEC_W-1:0]    rem_q;

  logic idx_lt, take, table_full;
  logic [hpt_pkg::CYC_W:0]    cyc_sum;
  logic [hpt_pkg::CYC_W-1:0]  cyc_new;
  logic [hpt_pkg::EXEC_W-1:0] exec_new;
  logic [hpt_pkg::IDX_W-1:0]  wr_idx;
  logic [hpt_pkg::EXEC_W:0]   div_sh;
  logic                       div_ge;
  logic [hpt_pkg::REQ_W-1:0]  want_cap;
  logic [hpt_pkg::LIM_W-1:0]  want_ext, used_ext, limit_d;
  logic [hpt_pkg::AVG_W-1:0]  avg;

  assign idx_lt     = idx_q < used_q;
  assign table_full = used_q == hpt_pkg::CNT_W'(N);

  always_comb begin
    if (!rd_vld_q) begin
      take = 1'b0;
    end else if (cmd_i.qry_mode) begin
      take = !mask_q[rd_idx_q] && (!found_q || rd_cyc_q > best_cyc_q);
    end else begin
      take = !found_q && rd_pc_q == pc_q;
    end
  end

  // Saturating update of a hit slot, or first execution of a new one.
  assign cyc_sum  = {1'b0, best_cyc_q} + (hpt_pkg::CYC_W + 1)'(cyc_q);
  assign cyc_new  = !found_q ? hpt_pkg::CYC_W'(cyc_q)
                  : (cyc_sum[hpt_pkg::CYC_W] ? '1 : cyc_sum[hpt_pkg::CYC_W-1:0]);
  assign exec_new = !found_q ? hpt_pkg::EXEC_W'(1)
                  : ((&best_exec_q) ? best_exec_q : best_exec_q + 1'b1);
  assign wr_idx   = found_q ? best_idx_q : used_q[hpt_pkg::IDX_W-1:0];

  assign want_cap = (in_want_i > hpt_pkg::REQ_W'(hpt_pkg::MAX_RESULTS))
                  ? hpt_pkg::REQ_W'(hpt_pkg::MAX_RESULTS) : in_want_i;
  assign want_ext = hpt_pkg::LIM_W'(want_cap);
  assign used_ext = hpt_pkg::LIM_W'(used_q);
  assign limit_d  = (want_ext > used_ext) ? used_ext : want_ext;

  assign div_sh = {rem_q, quo_q[hpt_pkg::CYC_W-1]};
  assign div_ge = div_sh >= {1'b0, best_exec_q};

  always_comb begin
    if (best_exec_q == '0) begin
      avg = '0;
    end else if (|quo_q[hpt_pkg::CYC_W-1:hpt_pkg::AVG_W]) begin
      avg = '1;
    end else begin
      avg = quo_q[hpt_pkg::AVG_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rec_commit && (found_q || !table_full)) begin
      mem_exec[wr_idx] <= exec_new;
      mem_cyc[wr_idx]  <= cyc_new;
      if (!found_q) mem_pc[wr_idx] <= pc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_run && idx_lt) begin
      rd_idx_q  <= idx_q[hpt_pkg::IDX_W-1:0];
      rd_pc_q   <= mem_pc[idx_q[hpt_pkg::IDX_W-1:0]];
      rd_exec_q <= mem_exec[idx_q[hpt_pkg::IDX_W-1:0]];
      rd_cyc_q  <= mem_cyc[idx_q[hpt_pkg::IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q   <= '0;
      ovf_q    <= 1'b0;
      mask_q   <= '0;
      idx_q    <= '0;
      rd_vld_q <= 1'b0;
      found_q  <= 1'b0;
      limit_q  <= '0;
      empty_q  <= 1'b0;
      rank_q   <= '0;
      div_cnt_q <= '0;
    end else begin
      if (cmd_i.clear) begin
        used_q <= '0;
        ovf_q  <= 1'b0;
        mask_q <= '0;
      end
      if (cmd_i.rec_commit && !found_q) begin
        if (table_full) ovf_q <= 1'b1;
        else used_q <= used_q + 1'b1;
      end
      if (cmd_i.qry_init) begin
        mask_q  <= '0;
        limit_q <= limit_d;
        empty_q <= limit_d == '0;
        rank_q  <= '0;
      end
      if (cmd_i.rank_next) rank_q <= rank_q + 1'b1;
      if (cmd_i.pick) begin
        mask_q[best_idx_q] <= 1'b1;
        div_cnt_q <= hpt_pkg::DIV_CNT_W'(hpt_pkg::CYC_W);
      end else if (div_cnt_q != '0) begin
        div_cnt_q <= div_cnt_q - 1'b1;
      end
      if (cmd_i.scan_start) begin
        idx_q    <= '0;
        rd_vld_q <= 1'b0;
        found_q  <= 1'b0;
      end else begin
        rd_vld_q <= cmd_i.scan_run && idx_lt;
        if (cmd_i.scan_run && idx_lt) idx_q <= idx_q + 1'b1;
        if (take) found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      pc_q  <= in_pc_i;
      cyc_q <= in_cycles_i;
    end
    if (take) begin
      best_idx_q  <= rd_idx_q;
      best_pc_q   <= rd_pc_q;
      best_exec_q <= rd_exec_q;
      best_cyc_q  <= rd_cyc_q;
    end
    // Restoring divide, one quotient bit per cycle.
    if (cmd_i.pick) begin
      quo_q <= best_cyc_q;
      rem_q <= '0;
    end else if (div_cnt_q != '0) begin
      rem_q <= div_ge ? hpt_pkg::EXEC_W'(div_sh - {1'b0, best_exec_q})
                      : div_sh[hpt_pkg::EXEC_W-1:0];
      quo_q <= {quo_q[hpt_pkg::CYC_W-2:0], div_ge};
    end
  end

  // Result register
  logic out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_o.rank           <= empty_q ? '0 : rank_q;
      out_o.entry_valid    <= !empty_q;
      out_o.hot_pc         <= empty_q ? '0 : best_pc_q;
      out_o.executions     <= empty_q ? '0 : best_exec_q;
      out_o.total_cycles   <= empty_q ? '0 : best_cyc_q;
      out_o.average_cycles <= empty_q ? '0 : avg;
      out_o.table_overflow <= ovf_q;
      out_o.last           <= empty_q || sts_o.last_rank;
    end
  end

  assign out_o.valid = out_vld_q;

  assign sts_o.kind       = in_kind_i;
  assign sts_o.limit_zero = limit_d == '0;
  assign sts_o.scan_done  = !idx_lt && !rd_vld_q;
  assign sts_o.div_done   = div_cnt_q == '0;
  assign sts_o.out_free   = !out_vld_q || out_o.ready;
  assign sts_o.last_rank  = hpt_pkg::LIM_W'(rank_q) + 1'b1 == limit_q;
  assign sts_o.empty      = empty_q;

`ifndef SYNTHESIS
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= hpt_pkg::CNT_W'(N))
    else $error("slot count beyond table size");
  a_read_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> hpt_pkg::CNT_W'(rd_idx_q) < used_q)
    else $error("scan read of an unused slot");
  a_full_sets_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rec_commit && !found_q && table_full |=> ovf_q)
    else $error("dropped pc did not set overflow");
  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (!out_vld_q || out_o.ready))
    else $error("result register overwritten");
`endif

endmodule
